@@ sv/pa_pkg.sv @@
// primitive assembly package: mode and face kind codes, register indexes,
// configuration and face types, face building and culling functions
// no dependencies
`default_nettype none
package pa_pkg;

	localparam int INDEX_BITS_DEF = 16;
	localparam int VERT_W         = 16;
	localparam int POS_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;

	localparam logic [2:0] MODE_TRI_LIST   = 3'd0;
	localparam logic [2:0] MODE_TRI_STRIP  = 3'd1;
	localparam logic [2:0] MODE_TRI_FAN    = 3'd2;
	localparam logic [2:0] MODE_LINE_LIST  = 3'd3;
	localparam logic [2:0] MODE_LINE_STRIP = 3'd4;
	localparam logic [2:0] MODE_POINTS     = 3'd5;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_TRI   = 2'd2;
	localparam logic [1:0] KIND_QUAD  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_PRIM_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_QUADS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_DEGEN   = 2'd3;

	localparam logic [POS_W-1:0] QUAD_CORNERS = 16'd4;

	typedef logic [VERT_W-1:0] vert_t;

	typedef struct packed {
		logic [2:0]       prim_mode;
		logic [POS_W-1:0] strip_length;
		logic             keep_quads;
		logic             drop_degenerate;
	} cfg_t;

	typedef struct packed {
		logic       vld;
		logic [1:0] kind;
		vert_t      a;
		vert_t      b;
		vert_t      c;
		vert_t      d;
	} face_t;

	function automatic face_t put_face(logic [1:0] kind, vert_t a, vert_t b, vert_t c,
			vert_t d);
		face_t f;
		f.vld  = 1'b1;
		f.kind = kind;
		f.a    = a;
		f.b    = b;
		f.c    = c;
		f.d    = d;
		return f;
	endfunction

	function automatic face_t no_face();
		face_t f;
		f = '0;
		return f;
	endfunction

	function automatic face_t emit_line(logic drop, vert_t a, vert_t b);
		if (drop && a == b)
			return no_face();
		return put_face(KIND_LINE, a, b, '0, '0);
	endfunction

	function automatic face_t emit_tri(logic drop, vert_t a, vert_t b, vert_t c);
		if (drop && (a == b || b == c || c == a))
			return no_face();
		return put_face(KIND_TRI, a, b, c, '0);
	endfunction

	function automatic face_t emit_quad(logic drop, vert_t a, vert_t b, vert_t c,
			vert_t d);
		if (drop) begin
			if (a == b) return emit_tri(drop, b, c, d);
			if (b == c) return emit_tri(drop, c, d, a);
			if (c == d) return emit_tri(drop, d, a, b);
			if (d == a) return emit_tri(drop, a, b, c);
		end
		return put_face(KIND_QUAD, a, b, c, d);
	endfunction

endpackage
`default_nettype wire

@@ sv/pa_face.sv @@
// primitive assembly step logic: builds the face for the current index and
// the next assembly state; depends on pa_pkg
`default_nettype none
module pa_face #(
	parameter int IW = pa_pkg::INDEX_BITS_DEF
) (
	input  wire pa_pkg::cfg_t            cfg,
	input  wire logic [IW-1:0]           cur,
	input  wire logic                    draw_start,
	input  wire logic [pa_pkg::POS_W-1:0] pos_q,
	input  wire logic                    odd_q,
	input  wire logic [IW-1:0]           older_q,
	input  wire logic [IW-1:0]           newer_q,
	input  wire logic [IW-1:0]           pivot_q,
	output pa_pkg::face_t                face,
	output logic [pa_pkg::POS_W-1:0]     pos_n,
	output logic                         odd_n,
	output logic [IW-1:0]                older_n,
	output logic [IW-1:0]                newer_n,
	output logic [IW-1:0]                pivot_n
);

	logic [pa_pkg::POS_W-1:0] pos;
	logic [pa_pkg::POS_W-1:0] pos_inc;
	logic                     odd;
	logic                     odd_eff;
	logic [IW-1:0]            piv;
	pa_pkg::vert_t            vc;
	pa_pkg::vert_t            vo;
	pa_pkg::vert_t            vn;
	pa_pkg::vert_t            vp;

	assign pos     = draw_start ? '0 : pos_q;
	assign odd     = draw_start ? 1'b0 : odd_q;
	assign pos_inc = pos + 1'b1;
	assign odd_eff = (pos == '0) ? 1'b0 : odd;
	assign piv     = (pos == '0) ? cur : pivot_q;
	assign vc      = pa_pkg::vert_t'(cur);
	assign vo      = pa_pkg::vert_t'(older_q);
	assign vn      = pa_pkg::vert_t'(newer_q);
	assign vp      = pa_pkg::vert_t'(piv);

	always_comb begin
		face    = pa_pkg::no_face();
		pos_n   = pos;
		odd_n   = odd;
		older_n = newer_q;
		newer_n = cur;
		pivot_n = pivot_q;
		case (cfg.prim_mode)
			pa_pkg::MODE_TRI_LIST: begin
				if (pos >= 16'd2) begin
					face  = pa_pkg::emit_tri(cfg.drop_degenerate, vo, vn, vc);
					pos_n = '0;
				end else begin
					pos_n = pos_inc;
				end
			end
			pa_pkg::MODE_TRI_STRIP: begin
				odd_n = odd_eff;
				if (pos >= 16'd2) begin
					if (odd_eff)
						face = pa_pkg::emit_tri(cfg.drop_degenerate, vo, vc, vn);
					else
						face = pa_pkg::emit_tri(cfg.drop_degenerate, vo, vn, vc);
					odd_n = ~odd_eff;
				end
				pos_n = pos_inc;
				if (pos_inc == cfg.strip_length) begin
					pos_n = '0;
					odd_n = 1'b0;
				end
			end
			pa_pkg::MODE_TRI_FAN: begin
				pivot_n = piv;
				if (cfg.keep_quads && cfg.strip_length == pa_pkg::QUAD_CORNERS) begin
					if (pos == 16'd3)
						face = pa_pkg::emit_quad(cfg.drop_degenerate, vp, vo, vn, vc);
				end else if (pos >= 16'd2) begin
					face = pa_pkg::emit_tri(cfg.drop_degenerate, vp, vn, vc);
				end
				pos_n = pos_inc;
				if (pos_inc == cfg.strip_length) begin
					pos_n = '0;
					odd_n = 1'b0;
				end
			end
			pa_pkg::MODE_LINE_LIST: begin
				if (pos >= 16'd1) begin
					face  = pa_pkg::emit_line(cfg.drop_degenerate, vn, vc);
					pos_n = '0;
				end else begin
					pos_n = 16'd1;
				end
			end
			pa_pkg::MODE_LINE_STRIP: begin
				if (pos >= 16'd1)
					face = pa_pkg::emit_line(cfg.drop_degenerate, vn, vc);
				pos_n = pos_inc;
				if (pos_inc == cfg.strip_length) begin
					pos_n = '0;
					odd_n = 1'b0;
				end
			end
			pa_pkg::MODE_POINTS: begin
				face  = pa_pkg::put_face(pa_pkg::KIND_POINT, vc, '0, '0, '0);
				pos_n = '0;
			end
			default: begin
				// unused mode: index ignored, only the draw start clearing stays
				older_n = older_q;
				newer_n = newer_q;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/pa_out.sv @@
// primitive assembly result stage: output register with a skid register
// behind it; depends on pa_pkg
`default_nettype none
module pa_out (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire pa_pkg::face_t face,
	output logic               full,
	output logic               out_valid,
	input  wire logic          out_stall,
	output pa_pkg::face_t      out_face
);

	logic          main_v_q;
	logic          skid_v_q;
	pa_pkg::face_t main_q;
	pa_pkg::face_t skid_q;
	logic          out_xfer;

	assign out_xfer  = main_v_q && !out_stall;
	assign out_valid = main_v_q;
	assign out_face  = main_q;
	assign full      = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_xfer) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= load;
			end
		end else if (load) begin
			if (!main_v_q)
				main_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			if (skid_v_q)
				main_q <= skid_q;
			else if (load)
				main_q <= face;
		end else if (load) begin
			if (!main_v_q)
				main_q <= face;
			else
				skid_q <= face;
		end
	end

endmodule
`default_nettype wire

@@ sv/primitive_assembly.sv @@
// primitive assembly top level: configuration registers, assembly state,
// step logic and result stage; depends on pa_pkg, pa_face, pa_out
//
// usage
// - input channel: in_valid / in_stall carry vertex_index and draw_start;
//   draw_start on an index clears the strip position and winding first
// - output channel: out_valid / out_stall carry face_kind and vert_a..vert_d
// - config: cfg_we with cfg_index and cfg_data writes one register per cycle;
//   write only while no transfer is in flight (the block does not enforce it)
// - one index per cycle while in_stall is low; a completed face is registered
//   in the result stage; indices that complete no face give nothing
// - the assembly state registers and a two-entry result stage (output
//   register plus skid register) set the rate and latency
// - when the receiver stalls, one more face is held in the skid register and
//   in_stall rises only once that register is full
// - reset clears the state and the result stage and loads the register
//   defaults: triangle list, strip length 3, quads kept, degenerates culled
`default_nettype none
module primitive_assembly #(
	parameter int INDEX_BITS = pa_pkg::INDEX_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [15:0]                   vertex_index,
	input  wire logic                          draw_start,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         face_kind,
	output logic [15:0]                        vert_a,
	output logic [15:0]                        vert_b,
	output logic [15:0]                        vert_c,
	output logic [15:0]                        vert_d,
	input  wire logic                          cfg_we,
	input  wire logic [pa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pa_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = (INDEX_BITS < pa_pkg::VERT_W) ? INDEX_BITS : pa_pkg::VERT_W;

	pa_pkg::cfg_t             cfg_q;
	logic [pa_pkg::POS_W-1:0] pos_q;
	logic                     odd_q;
	logic [IW-1:0]            older_q;
	logic [IW-1:0]            newer_q;
	logic [IW-1:0]            pivot_q;

	logic [pa_pkg::POS_W-1:0] pos_n;
	logic                     odd_n;
	logic [IW-1:0]            older_n;
	logic [IW-1:0]            newer_n;
	logic [IW-1:0]            pivot_n;
	pa_pkg::face_t            face;
	pa_pkg::face_t            out_face;
	logic                     in_xfer;
	logic                     full;

	assign in_stall = full;
	assign in_xfer  = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prim_mode       <= pa_pkg::MODE_TRI_LIST;
			cfg_q.strip_length    <= 16'd3;
			cfg_q.keep_quads      <= 1'b1;
			cfg_q.drop_degenerate <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pa_pkg::REG_PRIM_MODE:    cfg_q.prim_mode       <= cfg_data[2:0];
				pa_pkg::REG_STRIP_LENGTH: cfg_q.strip_length    <= cfg_data;
				pa_pkg::REG_KEEP_QUADS:   cfg_q.keep_quads      <= cfg_data[0];
				pa_pkg::REG_DROP_DEGEN:   cfg_q.drop_degenerate <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			odd_q   <= 1'b0;
			older_q <= '0;
			newer_q <= '0;
			pivot_q <= '0;
		end else if (in_xfer) begin
			pos_q   <= pos_n;
			odd_q   <= odd_n;
			older_q <= older_n;
			newer_q <= newer_n;
			pivot_q <= pivot_n;
		end
	end

	pa_face #(
		.IW(IW)
	) u_face (
		.cfg        (cfg_q),
		.cur        (vertex_index[IW-1:0]),
		.draw_start (draw_start),
		.pos_q      (pos_q),
		.odd_q      (odd_q),
		.older_q    (older_q),
		.newer_q    (newer_q),
		.pivot_q    (pivot_q),
		.face       (face),
		.pos_n      (pos_n),
		.odd_n      (odd_n),
		.older_n    (older_n),
		.newer_n    (newer_n),
		.pivot_n    (pivot_n)
	);

	pa_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_xfer && face.vld),
		.face      (face),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_face  (out_face)
	);

	assign face_kind = out_face.kind;
	assign vert_a    = out_face.a;
	assign vert_b    = out_face.b;
	assign vert_c    = out_face.c;
	assign vert_d    = out_face.d;

endmodule
`default_nettype wire

@@ sv/pa_checker.sv @@
// primitive assembly port checker and its bind to the top level
// depends on pa_pkg and primitive_assembly
`default_nettype none
module pa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  face_kind,
	input wire logic [15:0] vert_b,
	input wire logic [15:0] vert_c,
	input wire logic [15:0] vert_d
);

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// input stalls only with a result waiting
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_quad_only_d: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && face_kind != pa_pkg::KIND_QUAD |-> vert_d == 16'd0)
		else $error("fourth corner set on non-quad");

	a_line_c: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (face_kind == pa_pkg::KIND_LINE || face_kind == pa_pkg::KIND_POINT)
		|-> vert_c == 16'd0)
		else $error("third corner set on line or point");

	a_point_b: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && face_kind == pa_pkg::KIND_POINT |-> vert_b == 16'd0)
		else $error("second corner set on point");

endmodule

bind primitive_assembly pa_checker u_pa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.face_kind (face_kind),
	.vert_b    (vert_b),
	.vert_c    (vert_c),
	.vert_d    (vert_d)
);
`default_nettype wire

@@ verif/tb_primitive_assembly.sv @@
`timescale 1ns / 1ps
// self-checking testbench for primitive_assembly: directed and random index streams
// checked against an in-bench face predictor; depends on pa_pkg and primitive_assembly
module tb_primitive_assembly;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_ITEMS   = 1050;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
	} face_rec_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic [15:0]                   vertex_index = '0;
	logic                          draw_start   = 1'b0;
	logic                          out_valid;
	logic                          out_stall    = 1'b0;
	logic [1:0]                    face_kind;
	logic [15:0]                   vert_a;
	logic [15:0]                   vert_b;
	logic [15:0]                   vert_c;
	logic [15:0]                   vert_d;
	logic                          cfg_we       = 1'b0;
	logic [pa_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [pa_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	// predictor copy of configuration and assembly state
	logic [2:0]  mode_r       = pa_pkg::MODE_TRI_LIST;
	logic [15:0] strip_len_r  = 16'd3;
	logic        keep_quads_r = 1'b1;
	logic        drop_degen_r = 1'b1;
	logic [15:0] strip_pos    = '0;
	logic [15:0] older_vtx    = '0;
	logic [15:0] newer_vtx    = '0;
	logic [15:0] pivot_vtx    = '0;
	logic        odd_tri      = 1'b0;

	face_rec_t faces_pending[$];
	int        face_errors = 0;
	int        idle_cycles = 0;
	bit        idle_on     = 1'b1;
	int        items_sent  = 0;

	primitive_assembly u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vertex_index (vertex_index),
		.draw_start   (draw_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.face_kind    (face_kind),
		.vert_a       (vert_a),
		.vert_b       (vert_b),
		.vert_c       (vert_c),
		.vert_d       (vert_d),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bit cull_line(logic [15:0] a, logic [15:0] b, output face_rec_t f);
		f = '{pa_pkg::KIND_LINE, a, b, 16'd0, 16'd0};
		return !(drop_degen_r && a == b);
	endfunction

	function automatic bit cull_tri(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			output face_rec_t f);
		f = '{pa_pkg::KIND_TRI, a, b, c, 16'd0};
		return !(drop_degen_r && (a == b || b == c || c == a));
	endfunction

	function automatic bit cull_quad(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d, output face_rec_t f);
		if (drop_degen_r) begin
			if (a == b) return cull_tri(b, c, d, f);
			if (b == c) return cull_tri(c, d, a, f);
			if (c == d) return cull_tri(d, a, b, f);
			if (d == a) return cull_tri(a, b, c, f);
		end
		f = '{pa_pkg::KIND_QUAD, a, b, c, d};
		return 1'b1;
	endfunction

	function automatic bit assemble_face(logic [15:0] idx, logic ds, output face_rec_t f);
		logic [15:0] p;
		logic [15:0] nxt;
		bit          hit;
		bit          restart;
		hit     = 1'b0;
		restart = 1'b0;
		nxt     = '0;
		f       = '0;
		if (ds) begin
			strip_pos = '0;
			odd_tri   = 1'b0;
		end
		p = strip_pos;
		case (mode_r)
			pa_pkg::MODE_TRI_LIST: begin
				if (p >= 16'd2) hit = cull_tri(older_vtx, newer_vtx, idx, f);
				else nxt = p + 16'd1;
			end
			pa_pkg::MODE_TRI_STRIP: begin
				if (p == 16'd0) odd_tri = 1'b0;
				if (p >= 16'd2) begin
					// odd triangles swap the last two corners
					if (odd_tri) hit = cull_tri(older_vtx, idx, newer_vtx, f);
					else hit = cull_tri(older_vtx, newer_vtx, idx, f);
					odd_tri = ~odd_tri;
				end
				restart = 1'b1;
			end
			pa_pkg::MODE_TRI_FAN: begin
				if (p == 16'd0) pivot_vtx = idx;
				if (keep_quads_r && strip_len_r == pa_pkg::QUAD_CORNERS) begin
					if (p == 16'd3)
						hit = cull_quad(pivot_vtx, older_vtx, newer_vtx, idx, f);
				end else if (p >= 16'd2) begin
					hit = cull_tri(pivot_vtx, newer_vtx, idx, f);
				end
				restart = 1'b1;
			end
			pa_pkg::MODE_LINE_LIST: begin
				if (p >= 16'd1) hit = cull_line(newer_vtx, idx, f);
				else nxt = 16'd1;
			end
			pa_pkg::MODE_LINE_STRIP: begin
				if (p >= 16'd1) hit = cull_line(newer_vtx, idx, f);
				restart = 1'b1;
			end
			pa_pkg::MODE_POINTS: begin
				f   = '{pa_pkg::KIND_POINT, idx, 16'd0, 16'd0, 16'd0};
				hit = 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
		if (restart) begin
			nxt = p + 16'd1;
			if (nxt == strip_len_r) begin
				nxt     = '0;
				odd_tri = 1'b0;
			end
		end
		strip_pos = nxt;
		older_vtx = newer_vtx;
		newer_vtx = idx;
		return hit;
	endfunction

	task automatic send_index(input logic [15:0] idx, input logic ds);
		face_rec_t f;
		if (idle_on && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		vertex_index <= idx;
		draw_start   <= ds;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (assemble_face(idx, ds, f)) faces_pending = {faces_pending, f};
	endtask

	// wait until every expected face has been seen, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (faces_pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pa_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			pa_pkg::REG_PRIM_MODE:    mode_r       = val[2:0];
			pa_pkg::REG_STRIP_LENGTH: strip_len_r  = val;
			pa_pkg::REG_KEEP_QUADS:   keep_quads_r = val[0];
			pa_pkg::REG_DROP_DEGEN:   drop_degen_r = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [2:0] mode, input logic [15:0] slen,
			input logic kq, input logic dd);
		settle();
		write_reg(pa_pkg::REG_PRIM_MODE, {13'd0, mode});
		write_reg(pa_pkg::REG_STRIP_LENGTH, slen);
		write_reg(pa_pkg::REG_KEEP_QUADS, {15'd0, kq});
		write_reg(pa_pkg::REG_DROP_DEGEN, {15'd0, dd});
		cfg_we <= 1'b0;
	endtask

	// reset register values: triangle list
	task automatic test_defaults();
		send_index(16'h0000, 1'b1);
		send_index(16'hffff, 1'b0);
		send_index(16'h0001, 1'b0);
	endtask

	task automatic test_points_lines();
		apply_config(pa_pkg::MODE_POINTS, 16'd3, 1'b1, 1'b1);
		send_index(16'hffff, 1'b1);
		send_index(16'h0000, 1'b0);
		apply_config(pa_pkg::MODE_LINE_LIST, 16'd3, 1'b1, 1'b1);
		send_index(16'h0005, 1'b1);
		send_index(16'h0005, 1'b0);
		send_index(16'h0000, 1'b0);
		send_index(16'hffff, 1'b0);
		// line strip shorter than two indices gives nothing
		apply_config(pa_pkg::MODE_LINE_STRIP, 16'd1, 1'b1, 1'b1);
		send_index(16'h0011, 1'b1);
		send_index(16'h0012, 1'b0);
	endtask

	task automatic test_strips();
		apply_config(pa_pkg::MODE_TRI_STRIP, 16'd5, 1'b0, 1'b1);
		send_index(16'd1, 1'b1);
		send_index(16'd2, 1'b0);
		send_index(16'd3, 1'b0);
		send_index(16'd4, 1'b0);
		// list mode entered past its last slot completes at once
		apply_config(pa_pkg::MODE_TRI_LIST, 16'd5, 1'b0, 1'b1);
		send_index(16'd9, 1'b0);
	endtask

	task automatic test_fans();
		apply_config(pa_pkg::MODE_TRI_FAN, pa_pkg::QUAD_CORNERS, 1'b1, 1'b1);
		// repeated neighbor collapses to a triangle
		send_index(16'd5, 1'b1);
		send_index(16'd5, 1'b0);
		send_index(16'd6, 1'b0);
		send_index(16'd7, 1'b0);
		// repeat only across opposite corners stays a quad
		send_index(16'd8, 1'b0);
		send_index(16'd9, 1'b0);
		send_index(16'd8, 1'b0);
		send_index(16'd10, 1'b0);
	endtask

	task automatic test_unused_modes();
		apply_config(3'd6, 16'd3, 1'b1, 1'b1);
		send_index(16'h1234, 1'b1);
	endtask

	task automatic test_random();
		int          phase;
		int          n;
		int          r;
		logic [2:0]  mode;
		logic [15:0] slen;
		logic [15:0] base;
		logic [15:0] idx;
		logic        ds;
		phase = 0;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			mode = (r < 18) ? 3'(r % 6) : 3'(6 + r - 18);
			r = $urandom_range(0, 9);
			if (r <= 6) slen = 16'($urandom_range(1, 8));
			else if (r == 7) slen = pa_pkg::QUAD_CORNERS;
			else if (r == 8) slen = 16'($urandom_range(0, 65535));
			else slen = (phase % 3 == 0) ? 16'd0 : ((phase % 3 == 1) ? 16'd1 : 16'hffff);
			case (phase)
				0: begin mode = pa_pkg::MODE_TRI_STRIP; slen = 16'hffff; end
				1: begin mode = pa_pkg::MODE_TRI_FAN;   slen = 16'd0;    end
				2: begin mode = 3'd7;                   slen = 16'd1;    end
				3: begin mode = pa_pkg::MODE_TRI_FAN;   slen = pa_pkg::QUAD_CORNERS; end
				default: ;
			endcase
			apply_config(mode, slen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			idle_on = !(phase >= 8 && phase <= 13);
			n = $urandom_range(10, 40);
			base = 16'($urandom_range(0, 65535));
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(99) < 60) idx = base + 16'($urandom_range(0, 5));
				else idx = 16'($urandom_range(0, 65535));
				if (i == 0) ds = ($urandom_range(99) < 75);
				else ds = ($urandom_range(99) < 3);
				send_index(idx, ds);
				if (phase == 20 && i == n / 2) settle();
			end
			phase++;
		end
	endtask

	always @(posedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 19);
	end

	always @(posedge clk) begin : face_check
		face_rec_t got;
		face_rec_t want;
		bit        extra;
		if (arst_n && out_valid && !out_stall) begin
			got   = '{face_kind, vert_a, vert_b, vert_c, vert_d};
			extra = (faces_pending.size() == 0);
			want  = extra ? '0 : faces_pending.pop_front();
			if (extra || got.kind !== want.kind || got.a !== want.a || got.b !== want.b ||
					got.c !== want.c || got.d !== want.d) begin
				face_errors++;
				if (face_errors <= 10)
					$display("face mismatch%s: expected %0d %h %h %h %h, got %0d %h %h %h %h",
						extra ? " (none pending)" : "", want.kind, want.a, want.b, want.c,
						want.d, got.kind, got.a, got.b, got.c, got.d);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_points_lines();
		test_strips();
		test_fans();
		test_unused_modes();
		test_random();
		settle();
		repeat (8) @(posedge clk);
		if (face_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
